// ===== rtl/in_order_delivery_reorder_buffer_macros.svh =====
// Assertion macros used by the checker file of the reorder buffer.
`ifndef IN_ORDER_DELIVERY_REORDER_BUFFER_MACROS_SVH
`define IN_ORDER_DELIVERY_REORDER_BUFFER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IODRB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IODRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/iodrb_pkg.sv =====
// Types and constants shared by the in-order delivery reorder buffer.
`timescale 1ns / 1ps

package iodrb_pkg;

  localparam int unsigned PEER_W = 4;
  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned TAG_W  = 16;
  // Distance into the window; it fits windows of up to 64 slots, a limit the block does not enforce.
  localparam int unsigned DIST_W = 6;

  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_MSG = 1'b1;

  typedef struct packed {
    logic [PEER_W-1:0] peer_id;
    logic [SEQ_W-1:0]  seq;
    logic [TAG_W-1:0]  payload_tag;
  } req_t;

  typedef struct packed {
    logic              kind;
    logic [PEER_W-1:0] peer_out;
    logic [SEQ_W-1:0]  seq_out;
    logic [TAG_W-1:0]  tag_out;
    logic              overflow;
    logic              last;
  } res_t;

  // What the front end decided about one request.
  typedef enum logic [1:0] {
    CLS_ACK,  // bad peer or duplicate: plain acknowledgement
    CLS_OVF,  // beyond the window: acknowledgement with overflow
    CLS_BUF,  // ahead of the expected number: store in the window
    CLS_EXP   // the expected number: deliver it and the run behind it
  } cls_e;

  typedef struct packed {
    cls_e              cls;
    logic [PEER_W-1:0] peer;
    logic [SEQ_W-1:0]  seq;
    logic [TAG_W-1:0]  tag;
    logic [DIST_W-1:0] delta;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } bk_state_e;

endpackage

// ===== rtl/iodrb_cmd_fifo.sv =====
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps

module iodrb_cmd_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  iodrb_pkg::cmd_t  wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output iodrb_pkg::cmd_t  rdata_o,
  output logic             empty_o
);
  import iodrb_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  logic       wptr_q, rptr_q;
  logic       do_wr, do_rd;
  cmd_t       mem_q [2];

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign do_wr   = wr_i & ~full_o;
  assign do_rd   = rd_i & ~empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    unique case ({do_wr, do_rd})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (do_wr) begin
        wptr_q <= ~wptr_q;
      end
      if (do_rd) begin
        rptr_q <= ~rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/iodrb_front.sv =====
// Front end: accepts requests and classifies them against the expected number.
`timescale 1ns / 1ps

module iodrb_front #(
  parameter int unsigned NUM_PEERS = 16,
  parameter int unsigned WINDOW    = 16,
  parameter int unsigned PW        = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  iodrb_pkg::req_t              req_i,
  output logic [PW-1:0]                ne_peer_o,
  input  logic [iodrb_pkg::SEQ_W-1:0]  ne_i,
  output logic                         cmd_wr_o,
  output iodrb_pkg::cmd_t              cmd_o,
  input  logic                         cmd_full_i,
  input  logic                         run_done_i
);
  import iodrb_pkg::*;

  logic             pending_q, pending_d;
  logic             accept, peer_ok, behind;
  logic [SEQ_W-1:0] delta;
  cls_e             cls;

  // While a delivery run is outstanding the expected number is moving.
  assign full_o    = cmd_full_i | pending_q;
  assign accept    = push_i & ~full_o;
  assign peer_ok   = (32'(req_i.peer_id) < NUM_PEERS);
  assign ne_peer_o = req_i.peer_id[PW-1:0];
  assign behind    = (req_i.seq < ne_i);
  assign delta     = req_i.seq - ne_i;

  always_comb begin
    priority if (!peer_ok || behind) begin
      cls = CLS_ACK;
    end else if (delta >= 32'(WINDOW)) begin
      cls = CLS_OVF;
    end else if (delta == '0) begin
      cls = CLS_EXP;
    end else begin
      cls = CLS_BUF;
    end
  end

  always_comb begin
    cmd_o.cls   = cls;
    cmd_o.peer  = req_i.peer_id;
    cmd_o.seq   = req_i.seq;
    cmd_o.tag   = req_i.payload_tag;
    cmd_o.delta = delta[DIST_W-1:0];
  end

  assign cmd_wr_o = accept;

  always_comb begin
    priority if (accept && (cls == CLS_EXP)) begin
      pending_d = 1'b1;
    end else if (run_done_i) begin
      pending_d = 1'b0;
    end else begin
      pending_d = pending_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
    end else begin
      pending_q <= pending_d;
    end
  end

endmodule

// ===== rtl/iodrb_back.sv =====
// Back end: per-peer window state, payload memory, delivery walk and result register.
`timescale 1ns / 1ps

module iodrb_back #(
  parameter int unsigned NUM_PEERS = 16,
  parameter int unsigned WINDOW    = 16,
  parameter int unsigned TAG_BITS  = 16,
  parameter int unsigned PW        = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [PW-1:0]                ne_peer_i,
  output logic [iodrb_pkg::SEQ_W-1:0]  ne_o,
  input  logic                         cmd_empty_i,
  input  iodrb_pkg::cmd_t              cmd_i,
  output logic                         cmd_rd_o,
  output logic                         run_done_o,
  output logic                         empty_o,
  input  logic                         pop_i,
  output iodrb_pkg::res_t              res_o
);
  import iodrb_pkg::*;

  localparam int unsigned LW = $clog2(WINDOW);
  localparam int unsigned HW = LW + 1;
  localparam int unsigned AW = PW + LW;
  localparam int unsigned SW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

  bk_state_e        state_q, state_d;
  logic [SEQ_W-1:0] ne_q    [NUM_PEERS];
  logic [LW-1:0]    head_q  [NUM_PEERS];
  logic [WINDOW-1:0] valid_q [NUM_PEERS];

  logic [PW-1:0]    cur_peer_q, cur_peer_d;
  logic [SEQ_W-1:0] cur_seq_q, cur_seq_d;
  logic [SW-1:0]    cur_tag_q, cur_tag_d;
  logic             from_mem_q, from_mem_d;
  logic [LW-1:0]    run_q, run_d;
  logic             cur_ld;

  logic             out_valid_q, out_valid_d;
  res_t             res_q, res_d;
  logic             load, out_free;

  logic [SW-1:0]    tag_mem [2**AW];
  logic [SW-1:0]    rdata_q;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;

  logic [PW-1:0]    cmd_peer;
  logic [HW-1:0]    slot_sum;
  logic [LW-1:0]    buf_slot;
  logic             set_v, clr_v, adv;
  logic [SEQ_W-1:0] nxt_seq;
  logic [LW-1:0]    head_cur, head_nxt;
  logic             more;

  assign ne_o = (32'(ne_peer_i) < NUM_PEERS) ? ne_q[ne_peer_i] : '0;

  assign cmd_peer = cmd_i.peer[PW-1:0];
  assign slot_sum = HW'(head_q[cmd_peer]) + HW'(cmd_i.delta[LW-1:0]);
  assign buf_slot = (slot_sum >= HW'(WINDOW)) ? LW'(slot_sum - HW'(WINDOW)) : LW'(slot_sum);

  // Successor of the message being delivered; the slot follows the 32-bit wrap.
  assign nxt_seq  = cur_seq_q + 32'd1;
  assign head_cur = head_q[cur_peer_q];
  assign head_nxt = ((nxt_seq == '0) || (head_cur == LW'(WINDOW - 1))) ? '0
                                                                       : head_cur + LW'(1);
  assign more     = valid_q[cur_peer_q][head_nxt] && (run_q != LW'(WINDOW - 1));

  assign out_free  = ~out_valid_q | pop_i;
  assign mem_waddr = {cmd_peer, buf_slot};
  assign mem_raddr = {cur_peer_q, head_nxt};

  always_comb begin
    state_d    = state_q;
    cmd_rd_o   = 1'b0;
    run_done_o = 1'b0;
    load       = 1'b0;
    res_d      = res_q;
    set_v      = 1'b0;
    clr_v      = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    adv        = 1'b0;
    cur_ld     = 1'b0;
    cur_peer_d = cur_peer_q;
    cur_seq_d  = cur_seq_q;
    cur_tag_d  = cur_tag_q;
    from_mem_d = from_mem_q;
    run_d      = run_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!cmd_empty_i && out_free) begin
          cmd_rd_o       = 1'b1;
          load           = 1'b1;
          res_d.kind     = KIND_ACK;
          res_d.peer_out = cmd_i.peer;
          res_d.seq_out  = cmd_i.seq;
          res_d.tag_out  = '0;
          res_d.overflow = (cmd_i.cls == CLS_OVF);
          res_d.last     = (cmd_i.cls != CLS_EXP);
          if ((cmd_i.cls == CLS_BUF) && !valid_q[cmd_peer][buf_slot]) begin
            set_v  = 1'b1;
            mem_we = 1'b1;
          end
          if (cmd_i.cls == CLS_EXP) begin
            state_d    = BK_RUN;
            cur_ld     = 1'b1;
            cur_peer_d = cmd_peer;
            cur_seq_d  = cmd_i.seq;
            cur_tag_d  = cmd_i.tag[SW-1:0];
            from_mem_d = 1'b0;
            run_d      = '0;
          end
        end
      end
      BK_RUN: begin
        if (out_free) begin
          load           = 1'b1;
          adv            = 1'b1;
          res_d.kind     = KIND_MSG;
          res_d.peer_out = PEER_W'(cur_peer_q);
          res_d.seq_out  = cur_seq_q;
          res_d.tag_out  = TAG_W'(from_mem_q ? rdata_q : cur_tag_q);
          res_d.overflow = 1'b0;
          res_d.last     = ~more;
          if (more) begin
            clr_v      = 1'b1;
            mem_re     = 1'b1;
            cur_ld     = 1'b1;
            cur_seq_d  = nxt_seq;
            from_mem_d = 1'b1;
            run_d      = run_q + LW'(1);
          end else begin
            state_d    = BK_IDLE;
            run_done_o = 1'b1;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  assign out_valid_d = load | (out_valid_q & ~pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_PEERS; i++) begin
        ne_q[i]    <= 32'd1;
        head_q[i]  <= LW'(1);
        valid_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (adv) begin
        ne_q[cur_peer_q]   <= nxt_seq;
        head_q[cur_peer_q] <= head_nxt;
      end
      if (set_v) begin
        valid_q[cmd_peer][buf_slot] <= 1'b1;
      end
      if (clr_v) begin
        valid_q[cur_peer_q][head_nxt] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
    if (cur_ld) begin
      cur_peer_q <= cur_peer_d;
      cur_seq_q  <= cur_seq_d;
      cur_tag_q  <= cur_tag_d;
      from_mem_q <= from_mem_d;
      run_q      <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tag_mem[mem_waddr] <= cmd_i.tag[SW-1:0];
    end
    if (mem_re) begin
      rdata_q <= tag_mem[mem_raddr];
    end
  end

  assign empty_o = ~out_valid_q;
  assign res_o   = res_q;

endmodule

// ===== rtl/in_order_delivery_reorder_buffer.sv =====
// Top level of the receive-side reorder buffer with in-order delivery.
//
//   Channel   Direction  Handshake           Payload
//   request   in         push / full         in_data_i  (peer_id, seq, payload_tag)
//   result    out        empty / pop         out_data_o (kind, peer_out, seq_out,
//                                                        tag_out, overflow, last)
//
// Each request yields one acknowledgement from the back end. A request carrying
// the expected number is followed by the delivery of itself and of the buffered
// messages released behind it, all through the single result register, with one
// read of the payload memory per released message.
// After accepting such a request the front end holds full high until its run
// is complete; requests already in the two-entry command queue are still served.
// Reset clears the valid bits and sets every expected number to one at once, so
// there is no clearing pass; payload memory contents are read only where valid.
`timescale 1ns / 1ps

module in_order_delivery_reorder_buffer #(
  parameter int unsigned NUM_PEERS = 16,
  parameter int unsigned WINDOW    = 16,
  parameter int unsigned TAG_BITS  = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  iodrb_pkg::req_t  in_data_i,
  output logic             empty,
  input  logic             pop,
  output iodrb_pkg::res_t  out_data_o
);
  import iodrb_pkg::*;

  // The peer field is four bits wide, so at most sixteen peers can ever be addressed.
  localparam int unsigned NPE = (NUM_PEERS < (2 ** PEER_W)) ? NUM_PEERS : (2 ** PEER_W);
  localparam int unsigned PW  = (NPE > 1) ? $clog2(NPE) : 1;

  logic             cmd_wr, cmd_full, cmd_rd, cmd_empty;
  cmd_t             cmd_in, cmd_out;
  logic [PW-1:0]    ne_peer;
  logic [SEQ_W-1:0] ne;
  logic             run_done;

  // The front end classifies each request against the peer's expected number.
  iodrb_front #(
    .NUM_PEERS (NPE),
    .WINDOW    (WINDOW),
    .PW        (PW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .req_i      (in_data_i),
    .ne_peer_o  (ne_peer),
    .ne_i       (ne),
    .cmd_wr_o   (cmd_wr),
    .cmd_o      (cmd_in),
    .cmd_full_i (cmd_full),
    .run_done_i (run_done)
  );

  // The queue lets the front keep accepting while the back end is stalled.
  iodrb_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cmd_wr),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .rd_i    (cmd_rd),
    .rdata_o (cmd_out),
    .empty_o (cmd_empty)
  );

  // The back end owns the window state and produces acknowledgements and deliveries.
  iodrb_back #(
    .NUM_PEERS (NPE),
    .WINDOW    (WINDOW),
    .TAG_BITS  (TAG_BITS),
    .PW        (PW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ne_peer_i   (ne_peer),
    .ne_o        (ne),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_rd_o    (cmd_rd),
    .run_done_o  (run_done),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (out_data_o)
  );

endmodule

// ===== rtl/iodrb_checker.sv =====
// Port-level assertions for the reorder buffer and their bind to the top level.
`timescale 1ns / 1ps
`include "in_order_delivery_reorder_buffer_macros.svh"

module iodrb_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             empty,
  input logic             pop,
  input iodrb_pkg::res_t  out_data_o
);
  import iodrb_pkg::*;

  // A waiting result stays on the ports unchanged until it is taken.
  `IODRB_ASSERT_NEXT(a_res_hold, !empty && !pop, !empty && $stable(out_data_o), "result changed while stalled")

  // Overflow only ever appears on the closing acknowledgement.
  `IODRB_ASSERT_NOW(a_ovf_ack, !empty && out_data_o.overflow, out_data_o.last && (out_data_o.kind == KIND_ACK), "overflow on a delivery or non-final result")

  // Once a run has started, its next delivery for the same peer follows at once.
  `IODRB_ASSERT_NEXT(a_run_next, !empty && pop && !out_data_o.last, !empty && (out_data_o.kind == KIND_MSG) && (out_data_o.peer_out == $past(out_data_o.peer_out)), "run broken after a non-final result")

  // Deliveries within a run carry consecutive sequence numbers.
  `IODRB_ASSERT_NEXT(a_run_seq, !empty && pop && !out_data_o.last && (out_data_o.kind == KIND_MSG), out_data_o.seq_out == ($past(out_data_o.seq_out) + 32'd1), "delivered sequence numbers not consecutive")

endmodule

bind in_order_delivery_reorder_buffer iodrb_checker u_iodrb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_data_o (out_data_o)
);

// ===== tb/sv/in_order_delivery_reorder_buffer_test.sv =====
// Self-checking testbench for the in-order delivery reorder buffer.
`timescale 1ns / 1ps

module in_order_delivery_reorder_buffer_test;
  import iodrb_pkg::*;

  localparam int unsigned NUM_PEERS  = 16;
  localparam int unsigned WINDOW     = 16;
  localparam int unsigned TAG_BITS   = 16;
  localparam int unsigned RESET_CYCS = 12;
  // Cycles with no request and no result accepted before the run is abandoned.
  localparam int unsigned STALL_LIMIT = 3000;
  // A released run delivers at most WINDOW messages after its acknowledgement.
  localparam int unsigned SETTLE_CYCS = 2 + WINDOW + 4;
  localparam int unsigned RANDOM_ITEMS = 280;

  typedef struct {
    req_t req;
    bit   drain_first;  // hold off until every awaited result has arrived
  } stim_t;

  typedef enum logic [1:0] {
    RX_EAGER,   // pop every cycle
    RX_COIN,    // pop on a coin toss
    RX_BURSTY,  // frequent short stalls
    RX_SPARSE   // rare long stalls
  } rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  req_t in_data_i = '0;
  logic empty;
  logic pop = 1'b0;
  res_t out_data_o;

  // Requests still to be sent, filled once at the start of the run.
  stim_t stimulus_q[$];
  // Generator's view of each peer's next expected number.
  logic [SEQ_W-1:0] gen_next[NUM_PEERS];

  // Sender state.
  logic        acc_valid = 1'b0;
  req_t        acc_item = '0;
  logic        stim_drained = 1'b0;
  logic        taken;
  logic        push_nx;
  int unsigned burst_left;
  int unsigned gap_left;

  // Predicted state of the block and the results it still owes.
  logic [SEQ_W-1:0] exp_next[NUM_PEERS];
  logic             slot_held[NUM_PEERS*WINDOW];
  logic [TAG_W-1:0] slot_payload[NUM_PEERS*WINDOW];
  res_t             awaited[$];
  int unsigned      outstanding = 0;
  int unsigned      failures = 0;

  // Receiver state.
  rx_mode_e    rx_mode;
  int unsigned rx_cycle;
  int unsigned stall_left;
  logic        pop_nx;
  res_t        want;

  int unsigned idle_cycles = 0;

  in_order_delivery_reorder_buffer #(
    .NUM_PEERS(NUM_PEERS),
    .WINDOW   (WINDOW),
    .TAG_BITS (TAG_BITS)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_data_i (in_data_i),
    .empty     (empty),
    .pop       (pop),
    .out_data_o(out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Prediction. Every request is acknowledged first. The expected number is
  // delivered together with the consecutive run held behind it; a later number
  // inside the window is held; anything else is acknowledged only.
  // ---------------------------------------------------------------------------
  task automatic predict_results(input req_t r);
    res_t             pend;
    logic [SEQ_W-1:0] ne;
    logic [SEQ_W-1:0] ahead;
    int unsigned      base;
    int unsigned      slot;
    pend          = '0;
    pend.kind     = KIND_ACK;
    pend.peer_out = r.peer_id;
    pend.seq_out  = r.seq;
    ne   = exp_next[r.peer_id];
    base = r.peer_id * WINDOW;
    ahead = r.seq - ne;
    if (r.seq < ne) begin
      // Already delivered: a duplicate.
    end else if (ahead >= WINDOW) begin
      pend.overflow = 1'b1;
    end else if (ahead != 0) begin
      slot = base + (r.seq % WINDOW);
      // A request already held is a duplicate and keeps its first payload.
      if (!slot_held[slot]) begin
        slot_held[slot]    = 1'b1;
        slot_payload[slot] = r.payload_tag;
      end
    end else begin
      awaited.push_back(pend);
      pend          = '0;
      pend.kind     = KIND_MSG;
      pend.peer_out = r.peer_id;
      pend.seq_out  = r.seq;
      pend.tag_out  = r.payload_tag;
      ne = ne + 1;
      for (int run = 0; run < WINDOW - 1; run++) begin
        slot = base + (ne % WINDOW);
        if (!slot_held[slot]) break;
        awaited.push_back(pend);
        pend          = '0;
        pend.kind     = KIND_MSG;
        pend.peer_out = r.peer_id;
        pend.seq_out  = ne;
        pend.tag_out  = slot_payload[slot];
        slot_held[slot] = 1'b0;
        ne = ne + 1;
      end
      exp_next[r.peer_id] = ne;
    end
    pend.last = 1'b1;
    awaited.push_back(pend);
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      failures++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation.
  // ---------------------------------------------------------------------------
  task automatic queue_item(input logic [PEER_W-1:0] p, input logic [SEQ_W-1:0] s,
                            input logic [TAG_W-1:0] t, input bit drain);
    stim_t item;
    item.req.peer_id     = p;
    item.req.seq         = s;
    item.req.payload_tag = t;
    item.drain_first     = drain;
    stimulus_q.push_back(item);
  endtask

  // A request that leaves the state of its peer alone: a duplicate, one just
  // past the window, one far beyond it, or a sequence number drawn at random.
  // The peer of a session in progress is avoided, since its expected number
  // is moving.
  task automatic add_noise(input int busy_peer);
    logic [PEER_W-1:0] p;
    logic [SEQ_W-1:0]  s;
    p = PEER_W'($urandom_range(0, NUM_PEERS - 1));
    if (int'(p) == busy_peer) p = p ^ 4'h1;
    case ($urandom_range(0, 3))
      0:       s = $urandom;
      1:       s = $urandom_range(0, gen_next[p] - 1);
      2:       s = gen_next[p] + WINDOW;
      default: s = gen_next[p] + WINDOW + $urandom_range(1, 100000);
    endcase
    queue_item(p, s, TAG_W'($urandom), 1'b0);
  endtask

  // A session sends k consecutive numbers of one peer in a shuffled order, with
  // the odd repeat and unrelated requests mixed in; afterwards all k have been
  // delivered, so the generator knows the new expected number.
  task automatic add_session(input bit drain);
    logic [SEQ_W-1:0]  order[WINDOW];
    logic [SEQ_W-1:0]  swap;
    logic [PEER_W-1:0] p;
    int unsigned       k;
    int unsigned       j;
    p = PEER_W'($urandom_range(0, NUM_PEERS - 1));
    k = ($urandom_range(0, 3) == 0) ? $urandom_range(9, WINDOW) : $urandom_range(1, 8);
    for (int i = 0; i < k; i++) order[i] = gen_next[p] + i;
    for (int i = k - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      swap     = order[i];
      order[i] = order[j];
      order[j] = swap;
    end
    for (int i = 0; i < k; i++) begin
      queue_item(p, order[i], TAG_W'($urandom), drain && (i == 0));
      if ($urandom_range(0, 6) == 0) queue_item(p, order[$urandom_range(0, i)],
                                                TAG_W'($urandom), 1'b0);
      if ($urandom_range(0, 7) == 0) add_noise(int'(p));
    end
    gen_next[p] = gen_next[p] + k;
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of requests with random gaps between them. A request marked
  // to drain first waits until nothing is in flight.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push         <= 1'b0;
      acc_valid    <= 1'b0;
      stim_drained <= 1'b0;
      burst_left   = 1;
      gap_left     = 0;
    end else begin
      taken = push && !full;
      acc_valid <= taken;
      if (taken) acc_item <= in_data_i;
      push_nx = push && !taken;
      if (!push_nx) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stimulus_q.size() != 0 &&
                     !(stimulus_q[0].drain_first &&
                       (taken || acc_valid || outstanding != 0))) begin
          in_data_i <= stimulus_q[0].req;
          stimulus_q.delete(0);
          push_nx = 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      push         <= push_nx;
      stim_drained <= (stimulus_q.size() == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver and checker. The request accepted at the previous edge is
  // predicted before any result is compared, so every result finds its
  // expectation already queued.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop         <= 1'b0;
      outstanding <= 0;
      rx_mode     = RX_EAGER;
      rx_cycle    = 0;
      stall_left  = 0;
      for (int i = 0; i < NUM_PEERS; i++) exp_next[i] = 1;
      for (int i = 0; i < NUM_PEERS * WINDOW; i++) slot_held[i] = 1'b0;
    end else begin
      if (acc_valid) predict_results(acc_item);
      if (pop && !empty) begin
        if (awaited.size() == 0) begin
          $error("result with no request awaiting it: seq_out %0h", out_data_o.seq_out);
          failures++;
        end else begin
          want = awaited.pop_front();
          check_field("kind", 64'(want.kind), 64'(out_data_o.kind));
          check_field("peer_out", 64'(want.peer_out), 64'(out_data_o.peer_out));
          check_field("seq_out", 64'(want.seq_out), 64'(out_data_o.seq_out));
          check_field("tag_out", 64'(want.tag_out), 64'(out_data_o.tag_out));
          check_field("overflow", 64'(want.overflow), 64'(out_data_o.overflow));
          check_field("last", 64'(want.last), 64'(out_data_o.last));
        end
      end
      outstanding <= awaited.size();

      // The stall pattern changes character at regular intervals.
      if (rx_cycle % 300 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_cycle++;
      if (stall_left > 0) begin
        stall_left--;
        pop_nx = 1'b0;
      end else begin
        case (rx_mode)
          RX_EAGER: pop_nx = 1'b1;
          RX_COIN:  pop_nx = 1'($urandom_range(0, 1));
          RX_BURSTY: begin
            if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 6);
            pop_nx = 1'b1;
          end
          default: begin
            if ($urandom_range(0, 39) == 0) stall_left = $urandom_range(10, 24);
            pop_nx = 1'b1;
          end
        endcase
      end
      pop <= pop_nx;
    end
  end

  // Watchdog: a run that stops moving is a failure.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NUM_PEERS; i++) gen_next[i] = 1;

    // Directed part. Zero lies below the first expected number of one.
    queue_item(4'h0, 32'h0000_0000, 16'hFFFF, 1'b0);
    // Largest sequence number on the last peer: far beyond the window.
    queue_item(4'hF, 32'hFFFF_FFFF, 16'h0000, 1'b0);
    // One past the window is acknowledged with overflow and not held.
    queue_item(4'h0, 32'd17, 16'h1234, 1'b0);
    // Two held out of order, then the expected one releases all three.
    queue_item(4'h0, 32'd3, 16'h8000, 1'b0);
    queue_item(4'h0, 32'd2, 16'h0001, 1'b0);
    queue_item(4'h0, 32'd1, 16'h7FFF, 1'b0);
    gen_next[0] = 4;
    // Fill the whole window of one peer from its far edge down.
    for (int s = WINDOW; s >= 2; s--) queue_item(4'h1, SEQ_W'(s), TAG_W'(16'hA500 + s), 1'b0);
    // Repeat of a held request: dropped, the first payload stays.
    queue_item(4'h1, 32'd9, 16'hFFFF, 1'b0);
    // The expected number releases the longest run the block can give.
    queue_item(4'h1, 32'd1, 16'h5A5A, 1'b1);
    queue_item(4'h1, 32'd5, 16'h0F0F, 1'b0);
    gen_next[1] = WINDOW + 1;

    // Random part: mostly well-formed sessions, some unrelated requests.
    for (int n = 0; stimulus_q.size() < 24 + RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 4) == 0) begin
        add_noise(-1);
      end else begin
        add_session((n == 0) || ($urandom_range(0, 19) == 0));
      end
    end

    repeat (RESET_CYCS) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Every request sent and every awaited result received.
    do @(posedge clk_i);
    while (!stim_drained || push || acc_valid || outstanding != 0);
    // Let any stray result show itself before the verdict.
    repeat (SETTLE_CYCS) @(posedge clk_i);
    #1;
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
